>>> hw/rtl/aes128_pkg.sv
package aes128_pkg;

   localparam int RoundCountDefault = 10;

   // Configuration register indexes
   localparam logic CsrKeyHigh = 1'b0;
   localparam logic CsrKeyLow  = 1'b1;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_type;

   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
   } rsp_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   // Multiply by x in GF(2^8)
   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte n of the state sits at bits 127-8n downward
   function automatic logic [7:0] get_byte(input logic [127:0] s, input int n);
      return s[127 - 8*n -: 8];
   endfunction

   // SubBytes and ShiftRows together
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(c*4 + r) -: 8] = SBOX[get_byte(s, ((c + r) % 4)*4 + r)];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3, all;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, c*4);
         a1 = get_byte(s, c*4 + 1);
         a2 = get_byte(s, c*4 + 2);
         a3 = get_byte(s, c*4 + 3);
         all = a0 ^ a1 ^ a2 ^ a3;
         t[127 - 32*c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                                a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
      end
      return t;
   endfunction

   // One key schedule step: four words from the previous four
   function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rcon);
      logic [31:0] w3, t, n0, n1, n2, n3;
      w3 = k[31:0];
      t  = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]}
           ^ {rcon, 24'h0};
      n0 = k[127:96] ^ t;
      n1 = k[95:64] ^ n0;
      n2 = k[63:32] ^ n1;
      n3 = w3 ^ n2;
      return {n0, n1, n2, n3};
   endfunction

endpackage

>>> hw/rtl/aes128_block_encrypt.sv
// Channel | Ports                          | Direction | Payload
// req     | req_valid, req_ready, req_data | in        | plaintext block
// rsp     | rsp_valid, rsp_ready, rsp_data | out       | ciphertext block
// csr     | csr_we, csr_index, csr_wdata   | in        | key halves
//
// One block per cycle while rsp is not stalled and no key schedule runs; each block passes through the round pipeline.
// A key write runs the key schedule, one round key per cycle, and holds req_ready
// low until the schedule has stored every round key.
// Reset is synchronous; it clears valid bits, keys and the schedule sequencer.
// A stalled rsp freezes the whole pipeline; nothing is dropped or repeated.
module aes128_block_encrypt #(
   parameter int ROUND_COUNT = aes128_pkg::RoundCountDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  aes128_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output aes128_pkg::rsp_type rsp_data,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [63:0]         csr_wdata
);

   localparam int StepWidth = $clog2(ROUND_COUNT + 1);

   logic [63:0]          key_high_ff, key_low_ff;
   logic                 busy_ff;
   logic [StepWidth-1:0] step_ff;
   logic [7:0]           rcon_ff;
   logic [127:0]         cur_ff, cur_in;
   logic [127:0]         rk_ff [ROUND_COUNT+1];
   logic [127:0]         st_ff [ROUND_COUNT+1];
   logic                 vld_ff [ROUND_COUNT+1];
   logic                 advance;

   // Key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            aes128_pkg::CsrKeyHigh: key_high_ff <= csr_wdata;
            aes128_pkg::CsrKeyLow:  key_low_ff  <= csr_wdata;
            default:                key_low_ff  <= key_low_ff;
         endcase
      end
   end

   // Next round key from the working word
   always_comb begin
      if (step_ff == '0) begin
         cur_in = {key_high_ff, key_low_ff};
      end else begin
         cur_in = aes128_pkg::key_next(cur_ff, rcon_ff);
      end
   end

   // Key schedule sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         rcon_ff <= 8'h01;
      end else if (csr_we) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
         rcon_ff <= 8'h01;
      end else if (busy_ff) begin
         if (step_ff != '0) begin
            rcon_ff <= aes128_pkg::xtime(rcon_ff);
         end
         if (step_ff == StepWidth'(ROUND_COUNT)) begin
            busy_ff <= 1'b0;
         end else begin
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   // Store round keys
   always_ff @(posedge clock) begin
      if (busy_ff && !csr_we) begin
         cur_ff         <= cur_in;
         rk_ff[step_ff] <= cur_in;
      end
   end

   assign advance   = !vld_ff[ROUND_COUNT] || rsp_ready;
   assign req_ready = advance && !busy_ff;

   // Initial AddRoundKey stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid && !busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff[0] <= req_data ^ rk_ff[0];
      end
   end

   // Round stages, the last one without MixColumns
   for (genvar k = 1; k <= ROUND_COUNT; k++) begin : g_round
      logic [127:0] sub_val;

      assign sub_val = aes128_pkg::sub_shift(st_ff[k-1]);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            if (k == ROUND_COUNT) begin
               st_ff[k] <= sub_val ^ rk_ff[k];
            end else begin
               st_ff[k] <= aes128_pkg::mix(sub_val) ^ rk_ff[k];
            end
         end
      end
   end

   assign rsp_valid = vld_ff[ROUND_COUNT];
   assign rsp_data  = st_ff[ROUND_COUNT];

endmodule

>>> hw/rtl/aes128_checker.sv
module aes128_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input aes128_pkg::rsp_type rsp_data,
   input logic                csr_we
);

   // Nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // Key schedule blocks new words
   a_key_busy: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("req_ready during key schedule");

   // Stalled output word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed under stall");

   // Intake stops while the output is stalled
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req_ready while rsp stalled");

endmodule

bind aes128_block_encrypt aes128_checker u_aes128_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_we    (csr_we)
);
